// ===== src/gregorian_date_add_days_unit_defines.svh =====
// Assertion macros shared by the checker of the date adder.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef GREGORIAN_DATE_ADD_DAYS_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GDAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("date adder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GDAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("date adder check failed");

`endif

// ===== src/gdad_pkg.sv =====
// Types, constants and the microprogram of the Gregorian date adder.
// Used by the sequencer, the datapath and the top level.
package gdad_pkg;

	localparam int unsigned YearW  = 14;
	localparam int unsigned MonthW = 7;
	localparam int unsigned DayW   = 7;
	localparam int unsigned OffW   = 16;
	localparam int unsigned YAccW  = 15;
	localparam int unsigned DAccW  = 17;
	localparam int unsigned UpcW   = 3;
	localparam int unsigned QuotW  = 10;
	localparam int unsigned RecipW = 13;
	localparam int unsigned RecipShift = 17;
	localparam logic [RecipW-1:0] Recip25 = 13'd5243;
	localparam logic [4:0] Mod25Last = 5'd24;
	localparam logic [MonthW-1:0] MonthDec = 7'd12;

	typedef enum logic [2:0] {
		OP_WAIT  = 3'd0,
		OP_QUOT  = 3'd1,
		OP_REM   = 3'd2,
		OP_CHECK = 3'd3,
		OP_WALK  = 3'd4,
		OP_EMIT  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS    = 3'd0,
		C_INPUT     = 3'd1,
		C_INVALID   = 3'd2,
		C_WALK_DONE = 3'd3,
		C_OUT_FREE  = 3'd4
	} cond_t;

	typedef enum logic {
		SEQ_NEXT = 1'b0,
		SEQ_HOLD = 1'b1
	} fall_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [UpcW-1:0] jmp;
		fall_t           fall;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic take;
	} ctrl_t;

	typedef struct packed {
		logic date_bad;
		logic walk_done;
		logic out_free;
	} stat_t;

	localparam logic [UpcW-1:0] STEP_WAIT  = 3'd0;
	localparam logic [UpcW-1:0] STEP_QUOT  = 3'd1;
	localparam logic [UpcW-1:0] STEP_REM   = 3'd2;
	localparam logic [UpcW-1:0] STEP_CHECK = 3'd3;
	localparam logic [UpcW-1:0] STEP_WALK  = 3'd4;
	localparam logic [UpcW-1:0] STEP_EMIT  = 3'd5;

	function automatic uword_t urom(input logic [UpcW-1:0] addr);
		uword_t w;
		unique case (addr)
			STEP_WAIT:  w = '{op: OP_WAIT,  cond: C_INPUT,     jmp: STEP_QUOT,  fall: SEQ_HOLD};
			STEP_QUOT:  w = '{op: OP_QUOT,  cond: C_ALWAYS,    jmp: STEP_REM,   fall: SEQ_NEXT};
			STEP_REM:   w = '{op: OP_REM,   cond: C_ALWAYS,    jmp: STEP_CHECK, fall: SEQ_NEXT};
			STEP_CHECK: w = '{op: OP_CHECK, cond: C_INVALID,   jmp: STEP_EMIT,  fall: SEQ_NEXT};
			STEP_WALK:  w = '{op: OP_WALK,  cond: C_WALK_DONE, jmp: STEP_EMIT,  fall: SEQ_HOLD};
			STEP_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_FREE,  jmp: STEP_WAIT,  fall: SEQ_HOLD};
			default:    w = '{op: OP_WAIT,  cond: C_ALWAYS,    jmp: STEP_WAIT,  fall: SEQ_HOLD};
		endcase
		return w;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd2:                                      len = leap ? 5'd29 : 5'd28;
			default:                                   len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

// ===== src/gregorian_date_add_days_unit.sv =====
// Top level of the Gregorian date adder: microcoded sequencer plus datapath.
// Depends on gdad_pkg, gdad_seq and gdad_dp.
//
// Usage: an input beat carries year_in, month_in, day_in and offset_days on
// the in channel; one result beat with date_valid, year_out, month_out and
// day_out leaves on the out channel for every input beat.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The block works on one date at a time and holds in_stall
// high from the beat it takes until its result is written to the output
// register.
// After it takes a beat the sequencer runs its quotient, remainder and check
// steps, then the month walk, then the emit step that writes the result
// register. The walk step subtracts one month length per cycle and crosses at
// most about 2160 month ends for the largest offset; the next beat can be
// taken in the cycle after the result is registered.
// An invalid date skips the walk and gives an all-zero result.
// Reset clears the step counter and the output valid flag. While the
// receiver stalls, the result register holds and the sequencer waits in
// its emit step.
module gregorian_date_add_days_unit import gdad_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [YearW-1:0]  year_in,
	input  logic [MonthW-1:0] month_in,
	input  logic [DayW-1:0]   day_in,
	input  logic [OffW-1:0]   offset_days,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              date_valid,
	output logic [YearW-1:0]  year_out,
	output logic [3:0]        month_out,
	output logic [4:0]        day_out
);

	ctrl_t ctrl;
	stat_t stat;

	gdad_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctrl     (ctrl),
		.in_stall (in_stall)
	);

	gdad_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.year_in     (year_in),
		.month_in    (month_in),
		.day_in      (day_in),
		.offset_days (offset_days),
		.out_stall   (out_stall),
		.stat        (stat),
		.out_valid   (out_valid),
		.date_valid  (date_valid),
		.year_out    (year_out),
		.month_out   (month_out),
		.day_out     (day_out)
	);

endmodule

// ===== src/gdad_seq.sv =====
// Microprogram sequencer: step counter, control store and jump logic.
// Depends on gdad_pkg for the control word and status types.
module gdad_seq import gdad_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  in_stall
);

	logic [UpcW-1:0] upc_q;
	uword_t          cw;
	logic            cond_hit;

	assign cw = urom(upc_q);

	always_comb begin
		unique case (cw.cond)
			C_ALWAYS:    cond_hit = 1'b1;
			C_INPUT:     cond_hit = in_valid;
			C_INVALID:   cond_hit = stat.date_bad;
			C_WALK_DONE: cond_hit = stat.walk_done;
			C_OUT_FREE:  cond_hit = stat.out_free;
			default:     cond_hit = 1'b0;
		endcase
	end

	assign in_stall  = (cw.op != OP_WAIT);
	assign ctrl.op   = cw.op;
	assign ctrl.take = (cw.op == OP_WAIT) && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_WAIT;
		end else if (cond_hit) begin
			upc_q <= cw.jmp;
		end else if (cw.fall == SEQ_NEXT) begin
			upc_q <= upc_q + 1'b1;
		end
	end

endmodule

// ===== src/gdad_dp.sv =====
// Datapath of the date adder: date registers, leap test, month walk and result register.
// Depends on gdad_pkg; driven by control words from gdad_seq.
module gdad_dp import gdad_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	input  logic [YearW-1:0]  year_in,
	input  logic [MonthW-1:0] month_in,
	input  logic [DayW-1:0]   day_in,
	input  logic [OffW-1:0]   offset_days,
	input  logic              out_stall,
	output stat_t             stat,
	output logic              out_valid,
	output logic              date_valid,
	output logic [YearW-1:0]  year_out,
	output logic [3:0]        month_out,
	output logic [4:0]        day_out
);

	logic [YAccW-1:0]  y_q;
	logic [MonthW-1:0] m_q;
	logic [DAccW-1:0]  d_q;
	logic [OffW-1:0]   off_q;
	logic [QuotW-1:0]  q_q;
	logic [4:0]        r25_q;
	logic              ok_q;
	logic              out_valid_q;
	logic              date_valid_q;
	logic [YearW-1:0]  year_q;
	logic [3:0]        month_q;
	logic [4:0]        day_q;

	logic [YearW+RecipW-1:0] prod;
	logic [YearW-1:0]        q25;
	logic [YearW-1:0]        diff;
	logic                    leap;
	logic [DAccW-1:0]        len;
	logic                    more;
	logic                    emit;

	assign prod = {{RecipW{1'b0}}, y_q[YearW-1:0]} * {{YearW{1'b0}}, Recip25};
	assign q25  = {q_q, 4'b0} + {1'b0, q_q, 3'b0} + {4'b0, q_q};
	assign diff = y_q[YearW-1:0] - q25;

	assign leap = (y_q[1:0] == 2'b00) && ((r25_q != 5'd0) || (y_q[3:0] == 4'd0));
	assign len  = {{(DAccW-5){1'b0}}, month_len(m_q[3:0], leap)};
	assign more = (d_q > len);

	assign stat.date_bad  = (y_q == '0) || (m_q == '0) || (m_q > MonthDec)
		|| (d_q == '0) || more;
	assign stat.walk_done = !more;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign emit = (ctrl.op == OP_EMIT) && stat.out_free;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_WAIT: begin
				if (ctrl.take) begin
					y_q   <= {1'b0, year_in};
					m_q   <= month_in;
					d_q   <= {{(DAccW-DayW){1'b0}}, day_in};
					off_q <= offset_days;
				end
			end
			OP_QUOT: begin
				q_q <= prod[RecipShift +: QuotW];
			end
			OP_REM: begin
				r25_q <= diff[4:0];
			end
			OP_CHECK: begin
				ok_q <= !stat.date_bad;
				if (!stat.date_bad) begin
					d_q <= d_q + {1'b0, off_q};
				end
			end
			OP_WALK: begin
				if (more) begin
					d_q <= d_q - len;
					if (m_q == MonthDec) begin
						m_q   <= 7'd1;
						y_q   <= y_q + 1'b1;
						r25_q <= (r25_q == Mod25Last) ? 5'd0 : r25_q + 1'b1;
					end else begin
						m_q <= m_q + 1'b1;
					end
				end
			end
			OP_EMIT: begin
				if (emit) begin
					date_valid_q <= ok_q;
					year_q       <= ok_q ? y_q[YearW-1:0] : '0;
					month_q      <= ok_q ? m_q[3:0] : '0;
					day_q        <= ok_q ? d_q[4:0] : '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign date_valid = date_valid_q;
	assign year_out   = year_q;
	assign month_out  = month_q;
	assign day_out    = day_q;

endmodule

// ===== src/gdad_checker.sv =====
// Port-level checker for the date adder and its bind to the top level.
// Depends on gdad_pkg and the macros in gregorian_date_add_days_unit_defines.svh.
`include "gregorian_date_add_days_unit_defines.svh"

module gdad_checker import gdad_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              date_valid,
	input logic [YearW-1:0]  year_out,
	input logic [3:0]        month_out,
	input logic [4:0]        day_out
);

	// A result waiting under stall stays offered.
	`GDAD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// The block takes one date at a time.
	`GDAD_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall)

	// An invalid date gives all-zero result fields.
	`GDAD_ASSERT_NOW(a_invalid_zero, clk, arst_n, out_valid && !date_valid,
		(year_out == '0) && (month_out == 4'd0) && (day_out == 5'd0))

	// A valid result names a real month and a nonzero day.
	`GDAD_ASSERT_NOW(a_valid_range, clk, arst_n, out_valid && date_valid,
		(month_out >= 4'd1) && (month_out <= 4'd12) && (day_out != 5'd0))

endmodule

bind gregorian_date_add_days_unit gdad_checker u_gdad_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for gregorian_date_add_days_unit: a queue-fed driver, a monitor
// that predicts each result date, and random idling on both channels.
// Depends on gdad_pkg for the port widths and on the unit under test.
module testbench import gdad_pkg::*;;

	localparam int StuckLimit = 20000;
	localparam int PhaseItems = 62;

	typedef struct packed {
		logic [YearW-1:0]  year;
		logic [MonthW-1:0] month;
		logic [DayW-1:0]   day;
		logic [OffW-1:0]   offset;
	} date_item_t;

	typedef struct packed {
		logic             ok;
		logic [YearW-1:0] year;
		logic [3:0]       month;
		logic [4:0]       day;
	} date_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [YearW-1:0]  year_in = '0;
	logic [MonthW-1:0] month_in = '0;
	logic [DayW-1:0]   day_in = '0;
	logic [OffW-1:0]   offset_days = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              date_valid;
	logic [YearW-1:0]  year_out;
	logic [3:0]        month_out;
	logic [4:0]        day_out;

	date_item_t   dates_to_send[$];
	date_result_t future_dates[$];
	date_item_t   next_date;
	date_result_t want;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           dates_queued = 0;
	int           dates_checked = 0;
	int           errors = 0;
	int           stuck_cycles = 0;
	bit           in_taken = 1'b0;
	bit           out_taken = 1'b0;

	gregorian_date_add_days_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.year_in(year_in),
		.month_in(month_in),
		.day_in(day_in),
		.offset_days(offset_days),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.date_valid(date_valid),
		.year_out(year_out),
		.month_out(month_out),
		.day_out(day_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit is_leap_year(int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int days_in_month(int m, int y);
		int lengths[13];
		lengths = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m < 1 || m > 12)
			return 0;
		if (m == 2 && is_leap_year(y))
			return 29;
		return lengths[m];
	endfunction

	function automatic date_result_t date_after_offset(date_item_t it);
		date_result_t r;
		int y;
		int m;
		int d;
		int len;
		r = '0;
		y = int'(it.year);
		m = int'(it.month);
		d = int'(it.day);
		if (y < 1 || m < 1 || m > 12 || d < 1 || d > days_in_month(m, y))
			return r;
		d += int'(it.offset);
		len = days_in_month(m, y);
		while (d > len) begin
			d -= len;
			m++;
			if (m > 12) begin
				m = 1;
				y++;
			end
			len = days_in_month(m, y);
		end
		r.ok = 1'b1;
		r.year = y[YearW-1:0];
		r.month = m[3:0];
		r.day = d[4:0];
		return r;
	endfunction

	function automatic date_item_t random_date();
		date_item_t it;
		int y;
		int m;
		int len;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			it.year = YearW'($urandom_range(0, (1 << YearW) - 1));
			it.month = MonthW'($urandom_range(0, (1 << MonthW) - 1));
			it.day = DayW'($urandom_range(0, (1 << DayW) - 1));
			it.offset = OffW'($urandom_range(0, (1 << OffW) - 1));
			return it;
		end
		case ($urandom_range(0, 3))
			0: y = $urandom_range(1, (1 << YearW) - 1);
			1: y = $urandom_range(1583, 2400);
			2: y = $urandom_range(1, 163) * 100 + $urandom_range(0, 1) * 4;
			default: y = $urandom_range(16200, (1 << YearW) - 1);
		endcase
		m = $urandom_range(1, 12);
		len = days_in_month(m, y);
		it.year = YearW'(y);
		it.month = MonthW'(m);
		if (pick < 18)
			it.day = DayW'(len + 1);
		else if ($urandom_range(0, 1))
			it.day = DayW'(len - $urandom_range(0, 2));
		else
			it.day = DayW'($urandom_range(1, len));
		pick = $urandom_range(0, 99);
		if (pick < 15)
			it.offset = OffW'($urandom_range(0, (1 << OffW) - 1));
		else if (pick < 35)
			it.offset = OffW'($urandom_range(0, 3000));
		else
			it.offset = OffW'($urandom_range(0, 400));
		return it;
	endfunction

	task automatic queue_date(int y, int m, int d, int off);
		date_item_t it;
		it.year = YearW'(y);
		it.month = MonthW'(m);
		it.day = DayW'(d);
		it.offset = OffW'(off);
		dates_to_send.push_back(it);
		dates_queued++;
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (dates_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_date = dates_to_send.pop_front();
					in_valid <= 1'b1;
					year_in <= next_date.year;
					month_in <= next_date.month;
					day_in <= next_date.day;
					offset_days <= next_date.offset;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		out_taken = arst_n && out_valid && !out_stall;
		if (in_taken)
			future_dates.push_back(date_after_offset('{year_in, month_in, day_in, offset_days}));
		if (out_taken) begin
			if (future_dates.size() == 0) begin
				$error("result beat with no date pending");
				errors++;
			end else begin
				want = future_dates.pop_front();
				if (date_valid !== want.ok) begin
					$error("date_valid: expected %0d, got %0d", want.ok, date_valid);
					errors++;
				end
				if (year_out !== want.year) begin
					$error("year_out: expected %0d, got %0d", want.year, year_out);
					errors++;
				end
				if (month_out !== want.month) begin
					$error("month_out: expected %0d, got %0d", want.month, month_out);
					errors++;
				end
				if (day_out !== want.day) begin
					$error("day_out: expected %0d, got %0d", want.day, day_out);
					errors++;
				end
			end
			dates_checked++;
		end
		if (in_taken || out_taken)
			stuck_cycles = 0;
		else
			stuck_cycles++;
	end

	always @(posedge clk) begin
		if (stuck_cycles >= StuckLimit) begin
			$display("gregorian_date_add_days_unit: mismatch");
			$finish;
		end
	end

	initial begin
		queue_date(1, 1, 1, 0);
		queue_date(0, 1, 1, 5);
		queue_date(1, 0, 1, 5);
		queue_date(2024, 13, 1, 5);
		queue_date(2024, 127, 10, 5);
		queue_date(2024, 5, 0, 5);
		queue_date(2024, 5, 127, 5);
		queue_date(2023, 4, 31, 0);
		queue_date(2000, 2, 29, 0);
		queue_date(1900, 2, 29, 0);
		queue_date(2004, 2, 29, 365);
		queue_date(2001, 2, 29, 1);
		queue_date(1900, 2, 28, 1);
		queue_date(2000, 2, 28, 1);
		queue_date(2023, 12, 31, 1);
		queue_date(9999, 12, 31, 1);
		queue_date(2024, 1, 1, 65535);
		queue_date(1, 1, 1, 65535);
		queue_date(16383, 12, 31, 65535);
		queue_date(16383, 1, 31, 0);
		queue_date(16383, 127, 127, 65535);
		queue_date(2100, 2, 28, 1);
		queue_date(2400, 2, 28, 1);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 55 : (phase == 3) ? 33 : 0;
			recv_stall_pct = (phase == 2) ? 55 : (phase == 3) ? 33 : 0;
			for (int i = 0; i < PhaseItems; i++) begin
				dates_to_send.push_back(random_date());
				dates_queued++;
			end
			while (dates_to_send.size() != 0)
				@(negedge clk);
		end
		while (dates_checked < dates_queued)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && future_dates.size() == 0)
			$display("gregorian_date_add_days_unit: match");
		else
			$display("gregorian_date_add_days_unit: mismatch");
		$finish;
	end

endmodule
